// ===== hdl/wbps_pkg.sv =====
package wbps_pkg;

  localparam int unsigned PatWords   = 4;
  localparam int unsigned WordBits   = 64;
  localparam int unsigned LenBits    = 6;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned VecLimit   = 32;
  localparam int unsigned QDepth     = 2;
  localparam logic [7:0]  WildcardByte = 8'h2A;

  typedef enum logic [2:0] {
    REG_PAT_LOW    = 3'd0,
    REG_PAT_SECOND = 3'd1,
    REG_PAT_THIRD  = 3'd2,
    REG_PAT_HIGH   = 3'd3,
    REG_PAT_LENGTH = 3'd4,
    REG_BASE_ADDR  = 3'd5
  } cfg_reg_e;

  typedef logic [PatWords-1:0][WordBits-1:0] pat_words_t;

  // One pending result request: the start offset is turned into an address later.
  typedef struct packed {
    logic                found;
    logic [AddrBits-1:0] start;
  } q_entry_t;

  typedef struct packed {
    logic push;
    logic reported;
  } front_stat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/wildcard_byte_pattern_scanner_unit.sv =====
// Channel  Direction  Handshake                Payload
// in       request    in_valid_i / in_stall_o  in_data_byte_i, in_last_byte_i
// out      result     out_valid_o / out_stall_i out_found_o, out_match_address_o
// cfg      write      cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// One byte is accepted per cycle unless the input stalls; the shift-and update and
// all pattern compares happen combinationally in the front as the byte is taken,
// and any result request enters the queue and then the output register once that
// register is free. Reset clears the scan state, the configuration registers, the
// queue pointers and the output valid. The input stalls only when the two-entry
// result queue is full, which happens only while the output side stalls.
module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          in_data_byte_i,
  input  logic                in_last_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                out_found_o,
  output logic [AddrBits-1:0] out_match_address_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [WordBits-1:0] cfg_wdata_i
);

  localparam int unsigned VecW =
    (MAX_PATTERN_BYTES < VecLimit) ? MAX_PATTERN_BYTES : VecLimit;

  pat_words_t          words_q;
  logic [LenBits-1:0]  len_q;
  logic [AddrBits-1:0] base_q;

  logic        accept;
  q_entry_t    f_entry, q_entry;
  front_stat_t f_stat;
  q_stat_t     q_stat;
  logic        pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      len_q   <= '0;
      base_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PAT_LOW:    words_q[0] <= cfg_wdata_i;
        REG_PAT_SECOND: words_q[1] <= cfg_wdata_i;
        REG_PAT_THIRD:  words_q[2] <= cfg_wdata_i;
        REG_PAT_HIGH:   words_q[3] <= cfg_wdata_i;
        REG_PAT_LENGTH: len_q      <= cfg_wdata_i[LenBits-1:0];
        REG_BASE_ADDR:  base_q     <= cfg_wdata_i[AddrBits-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_stat.full;
  assign accept     = in_valid_i && !in_stall_o;

  wbps_front #(
    .VecW (VecW)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .data_i   (in_data_byte_i),
    .last_i   (in_last_byte_i),
    .words_i  (words_q),
    .len_i    (len_q),
    .entry_o  (f_entry),
    .stat_o   (f_stat)
  );

  wbps_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_stat.push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .stat_o  (q_stat)
  );

  wbps_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .entry_i (q_entry),
    .empty_i (q_stat.empty),
    .base_i  (base_q),
    .pop_o   (pop),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .found_o (out_found_o),
    .addr_o  (out_match_address_o)
  );

  // A not-found result always carries a zero address.
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_found_o |-> out_match_address_o == '0)
    else $error("not-found result with nonzero address");

  // The end of a region with no earlier match must produce a result request.
  a_last_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_byte_i && !f_stat.reported |-> f_stat.push)
    else $error("region ended without a result request");

  a_q_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("result queue both full and empty");

  // After a reported match, bytes of the same region produce nothing.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && f_stat.reported |-> !f_stat.push)
    else $error("second result request in one region");

endmodule

// ===== hdl/wbps_front.sv =====
module wbps_front import wbps_pkg::*; #(
  parameter int unsigned VecW = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_i,
  input  logic               last_i,
  input  pat_words_t         words_i,
  input  logic [LenBits-1:0] len_i,
  output q_entry_t           entry_o,
  output front_stat_t        stat_o
);

  logic [VecW-1:0]     vec_q, vec_d;
  logic [AddrBits-1:0] seen_q, seen_d;
  logic                rep_q, rep_d;

  logic [LenBits-1:0]  act_len;
  logic [VecW-1:0]     mask, keep, top, upd;
  logic                hit;
  logic [AddrBits-1:0] start;

  assign act_len = (len_i > LenBits'(VecW)) ? LenBits'(VecW) : len_i;

  // Per-position byte compare; each pattern byte sits at a fixed place in the words.
  for (genvar i = 0; i < VecW; i++) begin : g_cmp
    logic [7:0] pat;
    assign pat     = words_i[i / 8][(i % 8) * 8 +: 8];
    assign mask[i] = (pat == WildcardByte) || (pat == data_i);
    assign keep[i] = LenBits'(i) < act_len;
    assign top[i]  = LenBits'(i) == (act_len - LenBits'(1));
  end

  assign upd = ((vec_q << 1) | VecW'(1)) & mask & keep;

  always_comb begin
    vec_d = vec_q;
    hit   = 1'b0;
    start = seen_q;
    if (!rep_q) begin
      if (act_len == '0) begin
        hit = 1'b1;
      end else begin
        vec_d = upd;
        hit   = |(upd & top);
        start = seen_q - AddrBits'(act_len) + AddrBits'(1);
      end
    end
  end

  assign seen_d = (seen_q == '1) ? seen_q : seen_q + AddrBits'(1);
  assign rep_d  = rep_q | hit;

  assign entry_o.found   = hit;
  assign entry_o.start   = start;
  assign stat_o.push     = accept_i && !rep_q && (hit || last_i);
  assign stat_o.reported = rep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q  <= '0;
      seen_q <= '0;
      rep_q  <= 1'b0;
    end else if (accept_i) begin
      if (last_i) begin
        vec_q  <= '0;
        seen_q <= '0;
        rep_q  <= 1'b0;
      end else begin
        vec_q  <= vec_d;
        seen_q <= seen_d;
        rep_q  <= rep_d;
      end
    end
  end

endmodule

// ===== hdl/wbps_queue.sv =====
module wbps_queue import wbps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t entry_o,
  output q_stat_t  stat_o
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  q_entry_t            slots_q [QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign stat_o.full  = cnt_q == CntW'(QDepth);
  assign stat_o.empty = cnt_q == '0;
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign entry_o      = slots_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/wbps_back.sv =====
module wbps_back import wbps_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_entry_t            entry_i,
  input  logic                empty_i,
  input  logic [AddrBits-1:0] base_i,
  output logic                pop_o,
  output logic                valid_o,
  input  logic                stall_i,
  output logic                found_o,
  output logic [AddrBits-1:0] addr_o
);

  logic                valid_q;
  logic                found_q, found_d;
  logic [AddrBits-1:0] addr_q, addr_d;

  // The output register refills in the cycle it is taken.
  assign pop_o   = !empty_i && (!valid_q || !stall_i);
  assign found_d = entry_i.found;
  assign addr_d  = entry_i.found ? base_i + entry_i.start : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      found_q <= found_d;
      addr_q  <= addr_d;
    end
  end

  assign valid_o = valid_q;
  assign found_o = found_q;
  assign addr_o  = addr_q;

endmodule
